@@ rtl/lcapt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcapt_pkg
// Shared types, codes and sizes for the parent-table LCA engine.
// ----------------------------------------------------------------------------
package lcapt_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = 10;
    localparam int AW        = $clog2(MAX_NODES);

    // operation codes carried in func
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_LINK  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // query_status codes
    localparam logic [1:0] STATUS_FOUND = 2'd0;
    localparam logic [1:0] STATUS_SPLIT = 2'd1;
    localparam logic [1:0] STATUS_LIMIT = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_WALK,
        ST_CHECK,
        ST_RELOAD,
        ST_ALIGN,
        ST_DONE
    } lcapt_state_t;

    typedef struct packed {
        logic sweep_step;
        logic sweep_clear;
        logic link_wr;
        logic load_query;
        logic walk;
        logic reload;
        logic align;
        logic out_load;
    } lcapt_cmd_t;

    typedef struct packed {
        logic sweep_end;
        logic walk_done;
        logic check_pass;
        logic align_done;
        logic out_free;
    } lcapt_stat_t;

endpackage
`default_nettype wire

@@ rtl/lcapt_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcapt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcapt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/lcapt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcapt_ctrl
// Sequencer: table sweeps, link writes and the query walk/align phases.
// ----------------------------------------------------------------------------
module lcapt_ctrl
    import lcapt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [1:0]  func,
    input  wire lcapt_stat_t stat,
    output logic             in_stall,
    output lcapt_cmd_t       cmd
);

    lcapt_state_t state_reg;
    lcapt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (stat.sweep_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (func)
                        FUNC_CLEAR: state_next = ST_CLEAR;
                        FUNC_QUERY: state_next = ST_WALK;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (stat.sweep_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:  state_next = stat.check_pass ? ST_RELOAD : ST_DONE;
            ST_RELOAD: state_next = ST_ALIGN;
            ST_ALIGN:
            begin
                if (stat.align_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_INIT:   cmd.sweep_step = 1'b1;
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    case (func)
                        FUNC_CLEAR: cmd.sweep_clear = 1'b1;
                        FUNC_LINK:  cmd.link_wr     = 1'b1;
                        FUNC_QUERY: cmd.load_query  = 1'b1;
                        default:    cmd             = '0;
                    endcase
                end
            end
            ST_CLEAR:  cmd.sweep_step = 1'b1;
            ST_WALK:   cmd.walk       = 1'b1;
            ST_CHECK:  cmd            = '0;
            ST_RELOAD: cmd.reload     = 1'b1;
            ST_ALIGN:  cmd.align      = 1'b1;
            ST_DONE:   cmd.out_load   = stat.out_free;
            default:   cmd            = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/lcapt_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcapt_dp
// Parent table (two read copies), two walker lanes, sweep counter and
// the result register.
// ----------------------------------------------------------------------------
module lcapt_dp
    import lcapt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lcapt_cmd_t        cmd,
    input  wire logic [NODE_W-1:0] node_a,
    input  wire logic [NODE_W-1:0] node_b,
    input  wire logic [NODE_W-1:0] node_count,
    input  wire logic              out_stall,
    output lcapt_stat_t            stat,
    output logic                   out_valid,
    output logic [NODE_W-1:0]      ancestor_node,
    output logic [1:0]             query_status
);

    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_NODES - 1);

    // sweep counter
    logic [AW-1:0] sweep_idx_reg, sweep_idx_next;
    logic [AW-1:0] sweep_last_reg, sweep_last_next;

    // walker lanes
    logic [NODE_W-1:0] start_a_reg, start_a_next, start_b_reg, start_b_next;
    logic [NODE_W-1:0] lane_a_reg, lane_a_next, lane_b_reg, lane_b_next;
    logic [AW-1:0]     depth_a_reg, depth_a_next, depth_b_reg, depth_b_next;
    logic              done_a_reg, done_a_next, done_b_reg, done_b_next;
    logic              fail_reg, fail_next;
    logic              bad_reg, bad_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [NODE_W-1:0] anc_reg;
    logic [1:0]        status_reg;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [NODE_W-1:0] wr_data;
    logic [NODE_W-1:0] rdata_a, rdata_b;
    logic              link_ok;
    logic              align_hit;
    logic              roots_differ;
    logic [1:0]        res_status;

    assign link_ok = (32'(node_a) < MAX_NODES) && (32'(node_b) < MAX_NODES);
    assign wr_en   = cmd.sweep_step || (cmd.link_wr && link_ok);
    assign wr_addr = cmd.sweep_step ? sweep_idx_reg : AW'(node_b);
    assign wr_data = cmd.sweep_step ? NODE_W'(sweep_idx_reg) : node_a;

    // read address follows the next lane node so rdata is its parent
    lcapt_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (AW'(lane_a_next)),
        .rd_data (rdata_a)
    );

    lcapt_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (AW'(lane_b_next)),
        .rd_data (rdata_b)
    );

    assign align_hit    = (lane_a_reg == lane_b_reg) && (depth_a_reg == depth_b_reg);
    assign roots_differ = (lane_a_reg != lane_b_reg);

    always_comb
    begin
        sweep_idx_next  = sweep_idx_reg;
        sweep_last_next = sweep_last_reg;
        if (cmd.sweep_clear)
        begin
            sweep_idx_next = '0;
            if (32'(node_count) > MAX_NODES - 1)
            begin
                sweep_last_next = LAST_IDX;
            end
            else
            begin
                sweep_last_next = AW'(node_count);
            end
        end
        else if (cmd.sweep_step)
        begin
            sweep_idx_next = sweep_idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        start_a_next = start_a_reg;
        start_b_next = start_b_reg;
        lane_a_next  = lane_a_reg;
        lane_b_next  = lane_b_reg;
        depth_a_next = depth_a_reg;
        depth_b_next = depth_b_reg;
        done_a_next  = done_a_reg;
        done_b_next  = done_b_reg;
        fail_next    = fail_reg;
        bad_next     = bad_reg;
        if (cmd.load_query)
        begin
            start_a_next = node_a;
            start_b_next = node_b;
            lane_a_next  = node_a;
            lane_b_next  = node_b;
            depth_a_next = '0;
            depth_b_next = '0;
            done_a_next  = 1'b0;
            done_b_next  = 1'b0;
            fail_next    = 1'b0;
            bad_next     = !link_ok;
        end
        else if (cmd.walk)
        begin
            if (!done_a_reg)
            begin
                if (rdata_a == lane_a_reg)
                begin
                    done_a_next = 1'b1;
                end
                else if (depth_a_reg == LAST_IDX)
                begin
                    done_a_next = 1'b1;
                    fail_next   = 1'b1;
                end
                else
                begin
                    lane_a_next  = rdata_a;
                    depth_a_next = depth_a_reg + 1'b1;
                end
            end
            if (!done_b_reg)
            begin
                if (rdata_b == lane_b_reg)
                begin
                    done_b_next = 1'b1;
                end
                else if (depth_b_reg == LAST_IDX)
                begin
                    done_b_next = 1'b1;
                    fail_next   = 1'b1;
                end
                else
                begin
                    lane_b_next  = rdata_b;
                    depth_b_next = depth_b_reg + 1'b1;
                end
            end
        end
        else if (cmd.reload)
        begin
            lane_a_next = start_a_reg;
            lane_b_next = start_b_reg;
        end
        else if (cmd.align && !align_hit)
        begin
            // lift the deeper lane; step both once depths match
            if (depth_a_reg >= depth_b_reg)
            begin
                lane_a_next  = rdata_a;
                depth_a_next = depth_a_reg - 1'b1;
            end
            if (depth_b_reg >= depth_a_reg)
            begin
                lane_b_next  = rdata_b;
                depth_b_next = depth_b_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        if (bad_reg)
        begin
            res_status = STATUS_SPLIT;
        end
        else if (fail_reg)
        begin
            res_status = STATUS_LIMIT;
        end
        else if (roots_differ)
        begin
            res_status = STATUS_SPLIT;
        end
        else
        begin
            res_status = STATUS_FOUND;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_idx_reg  <= '0;
            sweep_last_reg <= LAST_IDX;
            done_a_reg     <= 1'b0;
            done_b_reg     <= 1'b0;
            fail_reg       <= 1'b0;
            bad_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            sweep_idx_reg  <= sweep_idx_next;
            sweep_last_reg <= sweep_last_next;
            done_a_reg     <= done_a_next;
            done_b_reg     <= done_b_next;
            fail_reg       <= fail_next;
            bad_reg        <= bad_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_a_reg <= start_a_next;
        start_b_reg <= start_b_next;
        lane_a_reg  <= lane_a_next;
        lane_b_reg  <= lane_b_next;
        depth_a_reg <= depth_a_next;
        depth_b_reg <= depth_b_next;
        if (cmd.out_load)
        begin
            status_reg <= res_status;
            anc_reg    <= (res_status == STATUS_FOUND) ? lane_a_reg : '0;
        end
    end

    assign stat.sweep_end  = (sweep_idx_reg == sweep_last_reg);
    assign stat.walk_done  = done_a_reg && done_b_reg;
    assign stat.check_pass = (res_status == STATUS_FOUND);
    assign stat.align_done = align_hit;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign ancestor_node = anc_reg;
    assign query_status  = status_reg;

endmodule
`default_nettype wire

@@ rtl/lowest_common_ancestor_parent_table_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lowest_common_ancestor_parent_table_core
// Parent-table tree store answering lowest-common-ancestor queries.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one beat per operation: clear,
// link or query; func 3 is dropped. Only a query returns a beat on the
// output channel (out_valid/out_stall), carrying ancestor_node and
// query_status.
// Link writes one table row; clear rewrites rows 0 to node_count to
// self-parent, one table row per cycle. A query walks both lanes to their
// roots, checks them, reloads the start nodes, lifts the deeper lane and
// then steps both lanes until they meet, and finally loads the result; a
// split or walk-limit query skips reload and align. Walks are bounded by
// the table size, so a cyclic chain ends in the walk-limit status after
// MAX_NODES-1 steps.
// Two copies of the parent table give each walker lane its own read port,
// one parent lookup per lane per cycle.
// After reset the block sweeps all MAX_NODES rows to self-parent with
// in_stall high. A finished result sits in the output register while
// out_stall is high; further beats are taken meanwhile, and a later query
// holds in its final cycle until the register frees up.
// ----------------------------------------------------------------------------
module lowest_common_ancestor_parent_table_core
    import lcapt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        func,
    input  wire logic [NODE_W-1:0] node_a,
    input  wire logic [NODE_W-1:0] node_b,
    input  wire logic [NODE_W-1:0] node_count,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [NODE_W-1:0]      ancestor_node,
    output logic [1:0]             query_status
);

    lcapt_cmd_t  cmd;
    lcapt_stat_t stat;

    lcapt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    lcapt_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .node_a        (node_a),
        .node_b        (node_b),
        .node_count    (node_count),
        .out_stall     (out_stall),
        .stat          (stat),
        .out_valid     (out_valid),
        .ancestor_node (ancestor_node),
        .query_status  (query_status)
    );

endmodule
`default_nettype wire

@@ sim/lowest_common_ancestor_parent_table_core_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lowest_common_ancestor_parent_table_core_tb
// Self-checking bench for the parent-table LCA engine. A short table of
// directed beats runs first: reset state, extremes, self link, split trees
// and cycle walks. Random tree-building episodes follow: clear, link a random
// forest, then query it, mixed with relinks, cycles and noise. A local
// parent-table model predicts every query answer not given by a directed
// row. The sender runs in bursts, and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module lowest_common_ancestor_parent_table_core_tb;
    import lcapt_pkg::*;

    localparam logic [1:0] FUNC_NONE  = 2'd3;
    localparam int         RANDOM_OPS = 1900;
    localparam int         CYCLE_CAP  = 16_000_000;
    localparam int         DRAIN      = 2 * MAX_NODES + 64;

    typedef struct packed {
        logic [NODE_W-1:0] anc;
        logic [1:0]        st;
    } lca_result_t;

    typedef struct packed {
        logic [1:0]        f;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic [NODE_W-1:0] cnt;
        logic              typed;
        lca_result_t       res;
    } op_row_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic [1:0]        func       = FUNC_NONE;
    logic [NODE_W-1:0] node_a     = '0;
    logic [NODE_W-1:0] node_b     = '0;
    logic [NODE_W-1:0] node_count = '0;
    logic              out_stall  = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic [NODE_W-1:0] ancestor_node;
    logic [1:0]        query_status;

    logic [NODE_W-1:0] parent_of [MAX_NODES];
    lca_result_t       pending_answers [$];
    op_row_t           directed_ops [$];
    int                errors     = 0;
    int                burst_left = 0;
    int                cycles     = 0;
    int                stall_left = 0;
    int                stall_mode = 0;

    lowest_common_ancestor_parent_table_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .node_a        (node_a),
        .node_b        (node_b),
        .node_count    (node_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ancestor_node (ancestor_node),
        .query_status  (query_status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_upto(input int cnt);
        for (int i = 0; i <= cnt; i++)
            parent_of[i] = NODE_W'(i);
    endfunction

    // moves needed to reach a root, or -1 once the walk limit is hit
    function automatic int hops_to_root(input logic [NODE_W-1:0] x);
        int n;
        n = 0;
        while (parent_of[x] != x)
        begin
            if (n >= MAX_NODES - 1)
                return -1;
            x = parent_of[x];
            n++;
        end
        return n;
    endfunction

    function automatic lca_result_t predict_lca(input logic [NODE_W-1:0] a,
                                                input logic [NODE_W-1:0] b);
        lca_result_t       r;
        int                da;
        int                db;
        logic [NODE_W-1:0] xa;
        logic [NODE_W-1:0] xb;
        r.anc = '0;
        r.st  = STATUS_SPLIT;
        da = hops_to_root(a);
        db = hops_to_root(b);
        if (da < 0 || db < 0)
        begin
            r.st = STATUS_LIMIT;
            return r;
        end
        xa = a;
        xb = b;
        // lift the deeper node, then climb both in step
        while (da > db)
        begin
            xa = parent_of[xa];
            da--;
        end
        while (db > da)
        begin
            xb = parent_of[xb];
            db--;
        end
        while (xa != xb && da > 0)
        begin
            xa = parent_of[xa];
            xb = parent_of[xb];
            da--;
        end
        if (xa == xb)
        begin
            r.anc = xa;
            r.st  = STATUS_FOUND;
        end
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] f, input int a, input int b,
                                    input int cnt, input logic typed,
                                    input int anc, input logic [1:0] st);
        op_row_t r;
        r.f       = f;
        r.a       = NODE_W'(a);
        r.b       = NODE_W'(b);
        r.cnt     = NODE_W'(cnt);
        r.typed   = typed;
        r.res.anc = NODE_W'(anc);
        r.res.st  = st;
        directed_ops.insert(directed_ops.size(), r);
    endfunction

    // drive one beat, hold it until taken, then update the table copy
    task automatic send_op(input logic [1:0] f, input int a, input int b,
                           input int cnt, input logic typed, input lca_result_t given);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        func       <= f;
        node_a     <= NODE_W'(a);
        node_b     <= NODE_W'(b);
        node_count <= NODE_W'(cnt);
        do
            @(posedge clk);
        while (in_stall);
        case (f)
            FUNC_CLEAR: clear_upto(cnt);
            FUNC_LINK:  parent_of[b] = NODE_W'(a);
            FUNC_QUERY: pending_answers.insert(pending_answers.size(),
                                               typed ? given
                                                     : predict_lca(NODE_W'(a), NODE_W'(b)));
            default: ;
        endcase
    endtask

    // receiver: stretches of no stall, light, heavy and periodic stalls
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 64);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_left % 5 < 2);
        endcase
    end

    always @(posedge clk)
    begin
        lca_result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got anc %0d status %0d",
                         $time, ancestor_node, query_status);
                errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (ancestor_node !== want.anc)
                begin
                    $display("%0t: ancestor_node expected %0d, got %0d",
                             $time, want.anc, ancestor_node);
                    errors++;
                end
                if (query_status !== want.st)
                begin
                    $display("%0t: query_status expected %0d, got %0d",
                             $time, want.st, query_status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_CAP)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int          sent_ops;
        int          n;
        int          base;
        int          cnt;
        int          reach;
        int          lo;
        int          nq;
        int          roll;
        int          i;
        int          j;
        int          tmp;
        int          ids [0:MAX_NODES-1];
        lca_result_t none;
        none     = '0;
        sent_ops = 0;
        clear_upto(MAX_NODES - 1);

        add_row(FUNC_QUERY, 0, 1023, 0, 1'b1, 0, STATUS_SPLIT);
        add_row(FUNC_QUERY, 1023, 1023, 1023, 1'b1, 1023, STATUS_FOUND);
        add_row(FUNC_QUERY, 0, 0, 0, 1'b1, 0, STATUS_FOUND);
        add_row(FUNC_NONE, 1023, 1023, 1023, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_LINK, 0, 1, 0, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_LINK, 0, 2, 0, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_LINK, 1, 3, 0, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_LINK, 1, 4, 0, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_LINK, 2, 5, 0, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_QUERY, 3, 4, 0, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_QUERY, 3, 5, 0, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_QUERY, 4, 1, 0, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_LINK, 1023, 0, 0, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_QUERY, 5, 1023, 0, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_LINK, 3, 3, 0, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_QUERY, 3, 4, 0, 1'b1, 0, STATUS_SPLIT);
        add_row(FUNC_LINK, 1022, 1023, 0, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_LINK, 1023, 1022, 0, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_QUERY, 1022, 0, 0, 1'b1, 0, STATUS_LIMIT);
        add_row(FUNC_QUERY, 4, 1023, 0, 1'b1, 0, STATUS_LIMIT);
        add_row(FUNC_CLEAR, 0, 0, 1023, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_QUERY, 1022, 1023, 0, 1'b1, 0, STATUS_SPLIT);
        add_row(FUNC_LINK, 5, 0, 0, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_CLEAR, 0, 0, 0, 1'b0, 0, STATUS_FOUND);
        add_row(FUNC_QUERY, 0, 5, 0, 1'b1, 0, STATUS_SPLIT);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_ops[k])
            send_op(directed_ops[k].f, directed_ops[k].a, directed_ops[k].b,
                    directed_ops[k].cnt, directed_ops[k].typed, directed_ops[k].res);

        while (sent_ops < RANDOM_OPS)
        begin
            // one episode: clear a window, grow a forest in it, then query it
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 200) : $urandom_range(2, 32);
            if ($urandom_range(0, 3) == 0)
            begin
                base = $urandom_range(0, MAX_NODES - n);
                cnt  = MAX_NODES - 1;
            end
            else
            begin
                base = 0;
                cnt  = ($urandom_range(0, 7) == 0) ? $urandom_range(n - 1, MAX_NODES - 1)
                                                   : n - 1;
            end
            send_op(FUNC_CLEAR, $urandom_range(0, MAX_NODES - 1),
                    $urandom_range(0, MAX_NODES - 1), cnt, 1'b0, none);
            sent_ops++;

            for (i = 0; i < n; i++)
                ids[i] = base + i;
            for (i = n - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = ids[i];
                ids[i] = ids[j];
                ids[j] = tmp;
            end

            // small reach builds deep chains, full reach builds bushy trees
            case ($urandom_range(0, 2))
                0: reach = 1;
                1: reach = 4;
                default: reach = MAX_NODES;
            endcase
            for (i = 1; i < n; i++)
            begin
                if ($urandom_range(0, 15) != 0)
                begin
                    lo = (i > reach) ? i - reach : 0;
                    send_op(FUNC_LINK, ids[$urandom_range(lo, i - 1)], ids[i], 0, 1'b0,
                            none);
                    sent_ops++;
                end
            end

            nq = $urandom_range(4, 16);
            for (int q = 0; q < nq; q++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                begin
                    send_op(FUNC_NONE, $urandom_range(0, MAX_NODES - 1),
                            $urandom_range(0, MAX_NODES - 1),
                            $urandom_range(0, MAX_NODES - 1), 1'b0, none);
                end
                else
                begin
                    if (roll < 12)
                        send_op(FUNC_QUERY, $urandom_range(0, MAX_NODES - 1),
                                $urandom_range(0, MAX_NODES - 1),
                                $urandom_range(0, MAX_NODES - 1), 1'b0, none);
                    else if (roll < 14)
                        send_op(FUNC_LINK, $urandom_range(0, MAX_NODES - 1),
                                $urandom_range(0, MAX_NODES - 1),
                                $urandom_range(0, MAX_NODES - 1), 1'b0, none);
                    else if (roll < 20)
                    begin
                        // re-parent upward in the shuffle order: acyclic unless a node already points down the order
                        i = $urandom_range(1, n - 1);
                        send_op(FUNC_LINK, ids[$urandom_range(0, i - 1)], ids[i], 0, 1'b0,
                                none);
                    end
                    else if (roll < 21)
                    begin
                        // point an early node at a later one: may close a cycle
                        i = $urandom_range(0, n - 2);
                        send_op(FUNC_LINK, ids[$urandom_range(i + 1, n - 1)], ids[i],
                                0, 1'b0, none);
                    end
                    else if (roll < 25)
                    begin
                        i = ids[$urandom_range(0, n - 1)];
                        send_op(FUNC_QUERY, i, i, 0, 1'b0, none);
                    end
                    else
                        send_op(FUNC_QUERY, ids[$urandom_range(0, n - 1)],
                                ids[$urandom_range(0, n - 1)], 0, 1'b0, none);
                    sent_ops++;
                end
            end
        end
        in_valid <= 1'b0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
